// ----- rtl/core/mcol_pkg.sv -----
// Package for the motor current offset / low-pass core.
// Holds widths, fixed-point constants, register indexes and the lane control struct.
// No dependencies.
`timescale 1ns / 1ps

package mcol_pkg;

  localparam int DEF_SAMPLE_BITS = 13;
  localparam int DEF_CAL_DELAY   = 300;

  localparam int ACC_BITS   = 22;
  localparam int W_BITS     = 9;
  localparam int DELAY_BITS = 9;
  localparam int SCALE_BITS = 16;
  localparam int CUR_BITS   = 32;
  localparam int OFF_BITS   = 13;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 1;

  localparam logic [W_BITS-1:0] ACC_GAIN     = 9'd300;
  localparam logic [W_BITS-1:0] GAIN_M1      = 9'd299;
  localparam logic [W_BITS-1:0] W_MIN        = 9'd2;
  localparam logic [W_BITS-1:0] W_ONE        = 9'd1;
  localparam logic [W_BITS-1:0] W_ZERO       = 9'd0;
  localparam logic [CFG_BITS-1:0] LI_LOW     = 16'd2;
  localparam logic [CFG_BITS-1:0] LI_HIGH    = 16'd300;
  localparam logic [9:0] W_DIVIDEND          = 10'd600;

  // floor(x/300) = ((x >> 2) * RECIP_75) >> RECIP_SHIFT, exact for x < 2^31
  localparam int RECIP_BITS  = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_BITS-1:0] RECIP_75 = 30'd916259690;

  localparam logic signed [SCALE_BITS-1:0] SCALE_RESET = 16'sd676;

  localparam logic [IDX_BITS-1:0] REG_LOG_INTERVAL = 1'd0;
  localparam logic [IDX_BITS-1:0] REG_SCALE_Q8     = 1'd1;

  typedef struct packed {
    logic              step_mul;
    logic              step_div;
    logic              step_acc;
    logic              step_cur;
    logic              cal;
    logic [W_BITS-1:0] mul_f;
    logic [W_BITS-1:0] mul_s;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/mcol_wdiv.sv -----
// Low-pass weight unit: holds log_interval and derives the weight 300, 2 or 600/interval.
// Radix-2 restoring divider, one quotient bit per cycle. Uses mcol_pkg.
`timescale 1ns / 1ps

module mcol_wdiv
  import mcol_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic [CFG_BITS-1:0] value,
  output logic [W_BITS-1:0]   weight,
  output logic                busy
);

  logic [9:0]        dvd;
  logic [W_BITS-1:0] divisor;
  logic [W_BITS-1:0] rem;
  logic [3:0]        count;
  logic [9:0]        rem_sh;
  logic              fits;

  assign rem_sh = {rem, dvd[9]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= ACC_GAIN;
      busy   <= 1'b0;
      count  <= '0;
    end else if (wr) begin
      if (value <= LI_LOW) begin
        weight <= ACC_GAIN;
        busy   <= 1'b0;
      end else if (value > LI_HIGH) begin
        weight <= W_MIN;
        busy   <= 1'b0;
      end else begin
        busy  <= 1'b1;
        count <= 4'd10;
      end
      divisor <= value[W_BITS-1:0];
      dvd     <= W_DIVIDEND;
      rem     <= '0;
    end else if (busy) begin
      rem   <= fits ? W_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[W_BITS-1:0];
      dvd   <= {dvd[8:0], fits};
      count <= count - 4'd1;
      if (count == 4'd1) begin
        busy   <= 1'b0;
        weight <= {dvd[7:0], fits};
      end
    end
  end

endmodule

// ----- rtl/core/mcol_lane.sv -----
// One channel lane: accumulator and offset update, current and offset-in-ADC-units.
// Divides by 300 through a reciprocal multiply. Uses mcol_pkg.
`timescale 1ns / 1ps

module mcol_lane
  import mcol_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)(
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctrl_t                    ctrl,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic signed [SCALE_BITS-1:0]  scale,
  output logic signed [CUR_BITS-1:0]    current,
  output logic [OFF_BITS-1:0]           offset
);

  localparam int P_BITS  = ACC_BITS + W_BITS;
  localparam int Q_BITS  = SAMPLE_BITS + W_BITS;
  localparam int R_BITS  = P_BITS - 2 + RECIP_BITS;
  localparam int PR_BITS = ACC_BITS + 1 + SCALE_BITS;
  localparam int OQ_BITS = ACC_BITS - 2 + RECIP_BITS;

  logic [ACC_BITS-1:0]        acc;
  logic [ACC_BITS-1:0]        off;
  logic [P_BITS-1:0]          p;
  logic [Q_BITS-1:0]          q;
  logic [R_BITS-1:0]          r;
  logic signed [PR_BITS-1:0]  prod;
  logic [OQ_BITS-1:0]         oq;
  logic [ACC_BITS-1:0]        acc_next;
  logic signed [ACC_BITS:0]   diff;
  logic signed [PR_BITS-1:0]  diff_x;
  logic signed [PR_BITS-1:0]  scale_x;
  logic signed [PR_BITS-1:0]  prod_sh;

  assign acc_next = r[RECIP_SHIFT +: ACC_BITS] + ACC_BITS'(q);
  assign diff     = $signed({1'b0, acc}) - $signed({1'b0, off});
  assign diff_x   = PR_BITS'(diff);
  assign scale_x  = PR_BITS'(scale);
  assign prod_sh  = prod >>> 8;
  assign current  = CUR_BITS'(prod_sh);
  assign offset   = oq[RECIP_SHIFT +: OFF_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      off <= '0;
    end else if (ctrl.step_acc) begin
      acc <= acc_next;
      if (ctrl.cal) begin
        off <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_mul) begin
      p <= P_BITS'(acc) * P_BITS'(ctrl.mul_f);
      q <= Q_BITS'(sample) * Q_BITS'(ctrl.mul_s);
    end
    if (ctrl.step_div) begin
      r <= R_BITS'(p[P_BITS-1:2]) * R_BITS'(RECIP_75);
    end
    if (ctrl.step_cur) begin
      prod <= diff_x * scale_x;
      oq   <= OQ_BITS'(off[ACC_BITS-1:2]) * OQ_BITS'(RECIP_75);
    end
  end

endmodule

// ----- rtl/core/motor_current_offset_lowpass_core.sv -----
// Top level of the two-channel motor current offset calibration and low-pass core.
// Instantiates mcol_wdiv and two mcol_lane lanes, merges lane results. Uses mcol_pkg.
//
// One word in gives one word out, and no new word is taken until the last one has left:
// after the accept cycle come four lane steps (accumulator multiply, reciprocal multiply
// for the /300, accumulator update, current multiply) and the load into the output
// register, which waits while the output is stalled. Writing log_interval with a value
// from 3 to 300 starts a serial divide for the weight 600/interval, during which
// in_stall is held high. Channel b current is sign inverted.
`timescale 1ns / 1ps

module motor_current_offset_lowpass_core
  import mcol_pkg::*;
#(
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
  parameter int CAL_DELAY_TICKS = DEF_CAL_DELAY
)(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        enabled,
  input  logic                        restart,
  input  logic [SAMPLE_BITS-1:0]      sample_a,
  input  logic [SAMPLE_BITS-1:0]      sample_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [CUR_BITS-1:0]  current_a_ua,
  output logic signed [CUR_BITS-1:0]  current_b_ua,
  output logic [OFF_BITS-1:0]         offset_a,
  output logic [OFF_BITS-1:0]         offset_b,
  output logic                        calibrating
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_DIV  = 3'd2;
  localparam logic [2:0] PH_ACC  = 3'd3;
  localparam logic [2:0] PH_CUR  = 3'd4;
  localparam logic [2:0] PH_OUT  = 3'd5;

  localparam logic [DELAY_BITS-1:0] DELAY_LOAD = DELAY_BITS'(CAL_DELAY_TICKS);

  logic [2:0]                    phase;
  logic [2:0]                    phase_next;
  logic                          was_enabled;
  logic [DELAY_BITS-1:0]         delay_count;
  logic                          restart_pending;
  logic signed [SCALE_BITS-1:0]  scale_q8;
  logic [SAMPLE_BITS-1:0]        s_a;
  logic [SAMPLE_BITS-1:0]        s_b;
  logic                          cal;
  logic [W_BITS-1:0]             mul_f;
  logic [W_BITS-1:0]             mul_s;
  logic [W_BITS-1:0]             weight;
  logic                          w_busy;
  logic                          w_wr;
  logic                          in_acc;
  logic                          out_load;
  logic                          rp_now;
  logic [DELAY_BITS-1:0]         dc_load;
  logic [DELAY_BITS-1:0]         dc_now;
  logic                          cal_now;
  lane_ctrl_t                    ctrl;
  logic signed [CUR_BITS-1:0]    cur_a;
  logic signed [CUR_BITS-1:0]    cur_b;
  logic [OFF_BITS-1:0]           off_a;
  logic [OFF_BITS-1:0]           off_b;

  assign w_wr     = cfg_we && (cfg_index == REG_LOG_INTERVAL);
  assign in_stall = (phase != PH_IDLE) || w_busy || w_wr;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (phase == PH_OUT) && (!out_valid || !out_stall);

  assign rp_now  = restart_pending || restart;
  assign dc_load = (enabled && !was_enabled) ? DELAY_LOAD : delay_count;
  assign dc_now  = (dc_load != '0) ? dc_load - 1'b1 : dc_load;
  assign cal_now = enabled && (dc_now == '0);

  assign ctrl.step_mul = (phase == PH_MUL);
  assign ctrl.step_div = (phase == PH_DIV);
  assign ctrl.step_acc = (phase == PH_ACC);
  assign ctrl.step_cur = (phase == PH_CUR);
  assign ctrl.cal      = cal;
  assign ctrl.mul_f    = mul_f;
  assign ctrl.mul_s    = mul_s;

  always_comb begin
    case (phase)
      PH_IDLE: phase_next = in_acc ? PH_MUL : PH_IDLE;
      PH_MUL:  phase_next = PH_DIV;
      PH_DIV:  phase_next = PH_ACC;
      PH_ACC:  phase_next = PH_CUR;
      PH_CUR:  phase_next = PH_OUT;
      PH_OUT:  phase_next = out_load ? PH_IDLE : PH_OUT;
      default: phase_next = PH_IDLE;
    endcase
  end

  mcol_wdiv u_wdiv (
    .clk    (clk),
    .rst    (rst),
    .wr     (w_wr),
    .value  (cfg_data),
    .weight (weight),
    .busy   (w_busy)
  );

  mcol_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (s_a),
    .scale   (scale_q8),
    .current (cur_a),
    .offset  (off_a)
  );

  mcol_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (s_b),
    .scale   (scale_q8),
    .current (cur_b),
    .offset  (off_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      was_enabled     <= 1'b0;
      delay_count     <= '0;
      restart_pending <= 1'b0;
      scale_q8        <= SCALE_RESET;
      out_valid       <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we && (cfg_index == REG_SCALE_Q8)) begin
        scale_q8 <= $signed(cfg_data);
      end
      if (in_acc) begin
        was_enabled     <= enabled;
        delay_count     <= dc_now;
        restart_pending <= cal_now ? 1'b0 : rp_now;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_a <= sample_a;
      s_b <= sample_b;
      cal <= cal_now;
      if (cal_now) begin
        mul_f <= rp_now ? W_ZERO : GAIN_M1;
        mul_s <= rp_now ? ACC_GAIN : W_ONE;
      end else begin
        mul_f <= ACC_GAIN - weight;
        mul_s <= weight;
      end
    end
    if (out_load) begin
      current_a_ua <= cur_a;
      current_b_ua <= -cur_b;
      offset_a     <= off_a;
      offset_b     <= off_b;
      calibrating  <= cal;
    end
  end

  a_step_sequence: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##4 (phase == PH_CUR))
    else $error("lane step sequence broken after accept");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    !w_busy |-> (weight >= W_MIN) && (weight <= ACC_GAIN))
    else $error("low-pass weight out of range");

  a_restart_consumed: assert property (@(posedge clk) disable iff (rst)
    (in_acc && cal_now) |=> !restart_pending)
    else $error("pending restart not cleared by calibrating word");

  a_delay_bound: assert property (@(posedge clk) disable iff (rst)
    delay_count <= DELAY_LOAD)
    else $error("calibration countdown above its load value");

endmodule

// ----- dv/motor_current_offset_lowpass_checker.sv -----
// Checker for the motor current offset / low-pass core: watches the word channels,
// keeps its own copy of the filter state and compares every output word.
// Depends on mcol_pkg for widths, register indexes and reset constants.
`timescale 1ns / 1ps

module motor_current_offset_lowpass_checker
  import mcol_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        enabled,
  input  logic                        restart,
  input  logic [DEF_SAMPLE_BITS-1:0]  sample_a,
  input  logic [DEF_SAMPLE_BITS-1:0]  sample_b,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [CUR_BITS-1:0]  current_a_ua,
  input  logic signed [CUR_BITS-1:0]  current_b_ua,
  input  logic [OFF_BITS-1:0]         offset_a,
  input  logic [OFF_BITS-1:0]         offset_b,
  input  logic                        calibrating,
  output int                          fail_count,
  output int                          words_waiting,
  output int                          words_checked,
  output int                          cal_words
);

  localparam int GAIN       = 300;
  localparam int FAST_LIMIT = 2;
  localparam int SLOW_W     = 2;
  localparam int PRINT_MAX  = 40;

  typedef struct {
    logic signed [CUR_BITS-1:0] cur_a;
    logic signed [CUR_BITS-1:0] cur_b;
    logic [OFF_BITS-1:0]        off_a;
    logic [OFF_BITS-1:0]        off_b;
    logic                       cal;
  } current_word_t;

  current_word_t                expected_q[$];
  logic [CFG_BITS-1:0]          interval;
  logic signed [SCALE_BITS-1:0] scale;
  logic                         was_on;
  logic [DELAY_BITS-1:0]        settle_left;
  logic                         seed_wanted;
  logic [ACC_BITS-1:0]          acc [2];
  logic [ACC_BITS-1:0]          cal_acc [2];
  int                           fails = 0;
  int                           checked = 0;
  int                           cals = 0;

  function automatic int lp_weight(input logic [CFG_BITS-1:0] li);
    if (li <= FAST_LIMIT) return GAIN;
    if (li > GAIN) return SLOW_W;
    return (2 * GAIN) / int'(li);
  endfunction

  // floor((acc - offset) * scale / 256), exact in 64 bits
  function automatic longint ua_of(input logic [ACC_BITS-1:0] a, input logic [ACC_BITS-1:0] o);
    longint d;
    d = longint'(a) - longint'(o);
    return (d * longint'(scale)) >>> 8;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    fails++;
    if (fails <= PRINT_MAX)
      $display("[%0t] word %0d: %s got %0d expected %0d", $time, checked, what, got, want);
  endtask

  task automatic predict_word(input logic en, input logic rs,
                              input logic [DEF_SAMPLE_BITS-1:0] sa,
                              input logic [DEF_SAMPLE_BITS-1:0] sb);
    current_word_t              w;
    logic [DEF_SAMPLE_BITS-1:0] s [2];
    longint                     nxt;
    longint                     cur;
    int                         wt;
    logic                       seed;
    s[0] = sa;
    s[1] = sb;
    if (rs) seed_wanted = 1'b1;
    if (en && !was_on) settle_left = DELAY_BITS'(DEF_CAL_DELAY);
    was_on = en;
    if (settle_left != 0) settle_left = settle_left - 1'b1;
    w.cal = en && (settle_left == 0);
    seed = seed_wanted;
    if (w.cal) seed_wanted = 1'b0;
    wt = lp_weight(interval);
    for (int ch = 0; ch < 2; ch++) begin
      if (w.cal && seed)
        nxt = longint'(s[ch]) * GAIN;
      else if (w.cal)
        nxt = longint'(acc[ch]) * (GAIN - 1) / GAIN + longint'(s[ch]);
      else
        nxt = longint'(acc[ch]) * (GAIN - wt) / GAIN + longint'(s[ch]) * wt;
      acc[ch] = nxt[ACC_BITS-1:0];
      if (w.cal) cal_acc[ch] = acc[ch];
    end
    cur = ua_of(acc[0], cal_acc[0]);
    w.cur_a = cur[CUR_BITS-1:0];
    cur = -ua_of(acc[1], cal_acc[1]);
    w.cur_b = cur[CUR_BITS-1:0];
    nxt = longint'(cal_acc[0]) / GAIN;
    w.off_a = nxt[OFF_BITS-1:0];
    nxt = longint'(cal_acc[1]) / GAIN;
    w.off_b = nxt[OFF_BITS-1:0];
    expected_q.push_back(w);
  endtask

  task automatic check_word();
    current_word_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("word with nothing expected, current_a_ua", current_a_ua, 0);
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (e.cal) cals++;
    if (current_a_ua !== e.cur_a) report_mismatch("current_a_ua", current_a_ua, e.cur_a);
    if (current_b_ua !== e.cur_b) report_mismatch("current_b_ua", current_b_ua, e.cur_b);
    if (offset_a !== e.off_a) report_mismatch("offset_a", {1'b0, offset_a}, {1'b0, e.off_a});
    if (offset_b !== e.off_b) report_mismatch("offset_b", {1'b0, offset_b}, {1'b0, e.off_b});
    if (calibrating !== e.cal)
      report_mismatch("calibrating", {1'b0, calibrating}, {1'b0, e.cal});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      interval    = '0;
      scale       = SCALE_RESET;
      was_on      = 1'b0;
      settle_left = '0;
      seed_wanted = 1'b0;
      acc[0]      = '0;
      acc[1]      = '0;
      cal_acc[0]  = '0;
      cal_acc[1]  = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOG_INTERVAL: interval = cfg_data;
          REG_SCALE_Q8:     scale = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_word(enabled, restart, sample_a, sample_b);
      if (out_valid && !out_stall) check_word();
    end
    fail_count    <= fails;
    words_waiting <= expected_q.size();
    words_checked <= checked;
    cal_words     <= cals;
  end

endmodule

// ----- dv/tb_motor_current_offset_lowpass_core.sv -----
// Testbench top for motor_current_offset_lowpass_core: drives tick words and register
// writes under several pacing patterns and gives the verdict.
// Depends on mcol_pkg, the core RTL and motor_current_offset_lowpass_checker.
`timescale 1ns / 1ps

module tb_motor_current_offset_lowpass_core;
  import mcol_pkg::*;

  localparam int  SAMPLE_MAX   = (1 << DEF_SAMPLE_BITS) - 1;
  localparam int  IDLE_PCT     = 79;
  localparam int  BOTH_PCT     = 23;
  localparam int  HOLD_CYCLES  = 150;
  localparam int  SETTLE_WAIT  = 8;
  localparam int  TAIL_CYCLES  = 20;
  localparam int  PHASES       = 8;
  localparam time LIMIT_NS     = 1000000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [IDX_BITS-1:0]         cfg_index = REG_LOG_INTERVAL;
  logic [CFG_BITS-1:0]         cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        enabled = 1'b0;
  logic                        restart = 1'b0;
  logic [DEF_SAMPLE_BITS-1:0]  sample_a = '0;
  logic [DEF_SAMPLE_BITS-1:0]  sample_b = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [CUR_BITS-1:0]  current_a_ua;
  logic signed [CUR_BITS-1:0]  current_b_ua;
  logic [OFF_BITS-1:0]         offset_a;
  logic [OFF_BITS-1:0]         offset_b;
  logic                        calibrating;

  int fail_count;
  int words_waiting;
  int words_checked;
  int cal_words;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int words_sent = 0;

  int on_left = 0;
  int off_left = 0;
  int noise_left = 0;
  int ep_tick = 0;
  int restart_tick = -1;
  logic [DEF_SAMPLE_BITS-1:0] base_a = '0;
  logic [DEF_SAMPLE_BITS-1:0] base_b = '0;

  motor_current_offset_lowpass_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .enabled      (enabled),
    .restart      (restart),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .current_a_ua (current_a_ua),
    .current_b_ua (current_b_ua),
    .offset_a     (offset_a),
    .offset_b     (offset_b),
    .calibrating  (calibrating)
  );

  motor_current_offset_lowpass_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .enabled       (enabled),
    .restart       (restart),
    .sample_a      (sample_a),
    .sample_b      (sample_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .current_a_ua  (current_a_ua),
    .current_b_ua  (current_b_ua),
    .offset_a      (offset_a),
    .offset_b      (offset_b),
    .calibrating   (calibrating),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .words_checked (words_checked),
    .cal_words     (cal_words)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("motor_current_offset_lowpass_core verification failed");
    $finish;
  end

  function automatic logic [DEF_SAMPLE_BITS-1:0] near_level(
      input logic [DEF_SAMPLE_BITS-1:0] base);
    int pick;
    int v;
    pick = $urandom_range(99);
    v = int'(base) + int'($urandom_range(64)) - 32;
    if (pick < 4) v = 0;
    else if (pick < 8) v = SAMPLE_MAX;
    else if (pick < 20) v = $urandom_range(SAMPLE_MAX);
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[DEF_SAMPLE_BITS-1:0];
  endfunction

  // mostly full enable episodes that reach calibration, some random toggling
  task automatic pick_word(output logic en, output logic rs);
    if (on_left == 0 && off_left == 0 && noise_left == 0) begin
      if ($urandom_range(99) < 75) begin
        off_left = $urandom_range(6, 1);
        on_left  = DEF_CAL_DELAY + $urandom_range(80, 1);
        ep_tick  = 0;
        case ($urandom_range(3))
          0:       restart_tick = -1;
          1:       restart_tick = $urandom_range(3);
          2:       restart_tick = $urandom_range(DEF_CAL_DELAY - 2);
          default: restart_tick = $urandom_range(on_left - 1, DEF_CAL_DELAY - 1);
        endcase
        base_a = DEF_SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
        base_b = DEF_SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      end else begin
        noise_left = $urandom_range(40, 5);
      end
    end
    if (noise_left != 0) begin
      noise_left--;
      en = 1'($urandom_range(1));
      rs = ($urandom_range(99) < 15);
    end else if (off_left != 0) begin
      off_left--;
      en = 1'b0;
      rs = ($urandom_range(99) < 3);
    end else begin
      on_left--;
      en = 1'b1;
      rs = (ep_tick == restart_tick);
      ep_tick++;
    end
  endtask

  task automatic send_word(input logic en, input logic rs,
                           input logic [DEF_SAMPLE_BITS-1:0] sa,
                           input logic [DEF_SAMPLE_BITS-1:0] sb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    enabled  <= en;
    restart  <= rs;
    sample_a <= sa;
    sample_b <= sb;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (words_waiting != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [CFG_BITS-1:0] li;
    logic [CFG_BITS-1:0] sc;
    logic                en;
    logic                rs;
    int                  n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, restart outside calibration, enable rise / fall / rise
    send_word(1'b0, 1'b0, '0, '0);
    send_word(1'b0, 1'b0, '1, '1);
    send_word(1'b0, 1'b1, 13'h1555, 13'h0AAA);
    send_word(1'b1, 1'b0, 13'h0AAA, 13'h1555);
    send_word(1'b1, 1'b1, '1, '0);
    send_word(1'b0, 1'b0, '0, '1);
    send_word(1'b1, 1'b0, 13'd4096, 13'd4095);
    send_word(1'b0, 1'b0, '1, '1);
    send_word(1'b0, 1'b0, '1, '1);
    send_word(1'b0, 1'b0, '0, '0);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      case (p)
        0: begin li = 16'd2;     sc = 16'd676;  n = 250; end
        1: begin li = 16'd1;     sc = 16'h7FFF; n = 150; send_idle_pct = IDLE_PCT; end
        2: begin li = 16'd3;     sc = 16'h8000; n = 150; recv_stall_pct = IDLE_PCT; end
        3: begin
          li = 16'd150; sc = 16'hFFFF; n = 150;
          send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT;
        end
        4: begin li = 16'd300;   sc = 16'd0;    n = 200; end
        5: begin li = 16'd301;   sc = CFG_BITS'($urandom_range(16'hFFFF)); n = 150;
          send_idle_pct = IDLE_PCT;
        end
        6: begin li = 16'hFFFF;  sc = 16'd676;  n = 100; recv_stall_pct = IDLE_PCT; end
        default: begin
          li = CFG_BITS'($urandom_range(299, 4)); sc = CFG_BITS'($urandom_range(16'hFFFF));
          n = 100;
          send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT;
        end
      endcase
      write_reg(REG_SCALE_Q8, sc);
      write_reg(REG_LOG_INTERVAL, li);
      if (p == 4) hold_req++;
      repeat (n) begin
        pick_word(en, rs);
        send_word(en, rs, near_level(base_a), near_level(base_b));
      end
      in_valid <= 1'b0;
      drain();
    end

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d tick words over %0d register settings under mixed pacing;",
             words_sent, PHASES + 1);
    $display("%0d result words compared, %0d of them from calibrating ticks.",
             words_checked, cal_words);
    if (fail_count == 0 && words_waiting == 0)
      $display("motor_current_offset_lowpass_core verification clean");
    else
      $display("motor_current_offset_lowpass_core verification failed");
    $finish;
  end

endmodule
